// ===== hdl/cira_pkg.sv =====
// Package for the checked integer reduction ALU.
// Holds opcodes, status and error codes and small sign helpers; depends on nothing.
package cira_pkg;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MOD = 3'd4;
    localparam logic [2:0] OP_POW = 3'd5;
    localparam logic [2:0] OP_MIN = 3'd6;
    localparam logic [2:0] OP_MAX = 3'd7;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_DIVZERO  = 2'd2;
    localparam logic [1:0] ERR_NEGEXP   = 2'd3;

    localparam logic [2:0] STATUS_OK  = 3'd0;
    localparam logic [2:0] STATUS_NAN = 3'd4;

    localparam logic [63:0] MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

    function automatic logic [63:0] magnitude(input logic [63:0] x);
        magnitude = x[63] ? (64'd0 - x) : x;
    endfunction

    function automatic logic [63:0] signed_bits(input logic neg, input logic [63:0] m);
        signed_bits = neg ? (64'd0 - m) : m;
    endfunction

endpackage

// ===== hdl/cira_if.sv =====
// Valid/ready channel interfaces for the checked integer reduction ALU.
// One interface for operand transactions, one for result transactions; no dependencies.
interface cira_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic signed [63:0] operand_value;
    logic               operand_is_number;
    logic               last_of_list;

    modport source (output valid, opcode, operand_value, operand_is_number, last_of_list,
                    input ready);
    modport sink   (input valid, opcode, operand_value, operand_is_number, last_of_list,
                    output ready);
endinterface

interface cira_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] result_value;
    logic [2:0]         status;

    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface

// ===== hdl/checked_integer_reduction_alu.sv =====
// Checked integer reduction ALU: folds a list of signed 64-bit operands under one operation
// taken from the first transaction and returns one result after the transaction marked last.
// Operands are taken one at a time. Multiply, divide and remainder run the 64 steps of the shared
// one-bit shift-add/subtract unit; power runs one multiplication per exponent step, up to 63
// multiplications for a base of magnitude two or more. A result sits in an output register,
// so the next operand is taken while it waits, unless a second result would overwrite it.
// Depends on cira_pkg and the interfaces in cira_if.sv.
module checked_integer_reduction_alu (
    input  logic       clk,
    input  logic       rst_n,
    cira_in_if.sink    operands,
    cira_out_if.source results
);
    import cira_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_POW  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [63:0] acc_reg, acc_next;
    logic [2:0]  op_reg, op_next;
    logic [1:0]  err_reg, err_next;
    logic        nan_reg, nan_next;
    logic        inlist_reg, inlist_next;
    logic        single_reg, single_next;
    logic [63:0] v_reg, v_next;
    logic        last_reg, last_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] y_reg, y_next;
    logic [63:0] p_reg, p_next;
    logic [63:0] e_reg, e_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        ovalid_reg, ovalid_next;
    logic [63:0] oval_reg, oval_next;
    logic [2:0]  ostat_reg, ostat_next;

    // Shared unit: one 66-bit adder serves both the multiply and the divide step.
    logic [65:0] add_a, add_b, add_res;
    logic        add_sub;

    logic        sa, sb, sbe, div_ge;
    logic [63:0] ma, mb, dm;
    logic [64:0] sum65;

    assign operands.ready       = (state_reg == S_IDLE);
    assign results.valid        = ovalid_reg;
    assign results.result_value = oval_reg;
    assign results.status       = ostat_reg;

    always_comb
    begin
        if (state_reg == S_DIV)
        begin
            add_a   = {1'b0, p_reg, y_reg[63]};
            add_b   = {2'b00, x_reg};
            add_sub = 1'b1;
        end
        else
        begin
            add_a   = {1'b0, p_reg, 1'b0};
            add_b   = y_reg[63] ? {2'b00, x_reg} : 66'd0;
            add_sub = 1'b0;
        end
        add_res = add_a + (add_sub ? ~add_b : add_b) + {65'd0, add_sub};
    end

    assign div_ge = ~add_res[65];
    assign sa     = acc_reg[63];
    assign sb     = v_reg[63];
    assign sbe    = sb ^ (op_reg == OP_SUB);
    assign ma     = magnitude(acc_reg);
    assign mb     = magnitude(v_reg);
    assign sum65  = {1'b0, ma} + {1'b0, mb};
    assign dm     = (ma >= mb) ? (ma - mb) : (mb - ma);

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        op_next     = op_reg;
        err_next    = err_reg;
        nan_next    = nan_reg;
        inlist_next = inlist_reg;
        single_next = single_reg;
        v_next      = v_reg;
        last_next   = last_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        p_next      = p_reg;
        e_next      = e_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        ovalid_next = ovalid_reg & ~results.ready;
        oval_next   = oval_reg;
        ostat_next  = ostat_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (operands.valid)
                begin
                    last_next = operands.last_of_list;
                    v_next    = operands.operand_value;
                    state_next = S_FIN;
                    if (!inlist_reg)
                    begin
                        op_next     = operands.opcode;
                        inlist_next = 1'b1;
                        single_next = 1'b1;
                        err_next    = ERR_NONE;
                        nan_next    = ~operands.operand_is_number;
                        acc_next    = operands.operand_is_number ?
                                      operands.operand_value : 64'd0;
                    end
                    else
                    begin
                        single_next = 1'b0;
                        if (!operands.operand_is_number)
                            nan_next = 1'b1;
                        else if (!nan_reg && err_reg == ERR_NONE)
                            state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                state_next = S_FIN;
                cnt_next   = 6'd63;
                p_next     = 64'd0;
                unique case (op_reg)
                    OP_ADD, OP_SUB:
                    begin
                        if (sa == sbe)
                        begin
                            if (sum65 > {1'b0, MAG_LIMIT})
                                err_next = ERR_OVERFLOW;
                            else
                                acc_next = signed_bits(sa, sum65[63:0]);
                        end
                        else if (dm > MAG_LIMIT)
                            err_next = ERR_OVERFLOW;
                        else
                            acc_next = signed_bits((ma >= mb) ? sa : sbe, dm);
                    end
                    OP_MUL:
                    begin
                        neg_next = sa ^ sb;
                        if (ma == 64'd0 || mb == 64'd0)
                            acc_next = 64'd0;
                        else
                        begin
                            x_next     = ma;
                            y_next     = mb;
                            state_next = S_MUL;
                        end
                    end
                    OP_DIV, OP_MOD:
                    begin
                        neg_next = (op_reg == OP_DIV) ? (sa ^ sb) : sa;
                        if (mb == 64'd0)
                            err_next = ERR_DIVZERO;
                        else
                        begin
                            x_next     = mb;
                            y_next     = ma;
                            state_next = S_DIV;
                        end
                    end
                    OP_POW:
                    begin
                        neg_next = sa & v_reg[0];
                        if (sb)
                            err_next = ERR_NEGEXP;
                        else if (ma == 64'd0)
                            acc_next = (v_reg != 64'd0) ? 64'd0 : 64'd1;
                        else if (ma == 64'd1)
                            acc_next = signed_bits(sa & v_reg[0], 64'd1);
                        else
                        begin
                            x_next     = ma;
                            y_next     = 64'd1;
                            e_next     = v_reg;
                            state_next = S_POW;
                        end
                    end
                    OP_MIN:
                    begin
                        if ($signed(v_reg) < $signed(acc_reg))
                            acc_next = v_reg;
                    end
                    OP_MAX:
                    begin
                        if ($signed(v_reg) > $signed(acc_reg))
                            acc_next = v_reg;
                    end
                    default:
                    begin
                        acc_next = acc_reg;
                    end
                endcase
            end
            S_MUL:
            begin
                // Multiplier bits go in from the top, so the partial product only grows and
                // the first excess over the limit already means overflow.
                y_next   = {y_reg[62:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (add_res[65:63] != 3'd0)
                begin
                    err_next   = ERR_OVERFLOW;
                    state_next = S_FIN;
                end
                else
                begin
                    p_next = add_res[63:0];
                    if (cnt_reg == 6'd0)
                    begin
                        if (op_reg == OP_POW)
                        begin
                            y_next     = add_res[63:0];
                            state_next = S_POW;
                        end
                        else
                        begin
                            acc_next   = signed_bits(neg_reg, add_res[63:0]);
                            state_next = S_FIN;
                        end
                    end
                end
            end
            S_DIV:
            begin
                y_next   = {y_reg[62:0], div_ge};
                p_next   = div_ge ? add_res[63:0] : add_a[63:0];
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    acc_next   = (op_reg == OP_DIV) ?
                                 signed_bits(neg_reg, {y_reg[62:0], div_ge}) :
                                 signed_bits(neg_reg, div_ge ? add_res[63:0] : add_a[63:0]);
                    state_next = S_FIN;
                end
            end
            S_POW:
            begin
                if (e_reg == 64'd0)
                begin
                    acc_next   = signed_bits(neg_reg, y_reg);
                    state_next = S_FIN;
                end
                else
                begin
                    e_next     = e_reg - 64'd1;
                    p_next     = 64'd0;
                    cnt_next   = 6'd63;
                    state_next = S_MUL;
                end
            end
            S_FIN:
            begin
                if (!last_reg)
                    state_next = S_IDLE;
                else if (!ovalid_reg || results.ready)
                begin
                    ovalid_next = 1'b1;
                    if (nan_reg)
                    begin
                        oval_next  = 64'd0;
                        ostat_next = STATUS_NAN;
                    end
                    else if (err_reg != ERR_NONE)
                    begin
                        oval_next  = 64'd0;
                        ostat_next = {1'b0, err_reg};
                    end
                    else
                    begin
                        oval_next  = (single_reg && op_reg == OP_SUB) ?
                                     (64'd0 - acc_reg) : acc_reg;
                        ostat_next = STATUS_OK;
                    end
                    acc_next    = 64'd0;
                    op_next     = OP_ADD;
                    err_next    = ERR_NONE;
                    nan_next    = 1'b0;
                    inlist_next = 1'b0;
                    single_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            acc_reg    <= 64'd0;
            op_reg     <= OP_ADD;
            err_reg    <= ERR_NONE;
            nan_reg    <= 1'b0;
            inlist_reg <= 1'b0;
            single_reg <= 1'b0;
            last_reg   <= 1'b0;
            cnt_reg    <= 6'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            op_reg     <= op_next;
            err_reg    <= err_next;
            nan_reg    <= nan_next;
            inlist_reg <= inlist_next;
            single_reg <= single_next;
            last_reg   <= last_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        p_reg     <= p_next;
        e_reg     <= e_next;
        neg_reg   <= neg_next;
        oval_reg  <= oval_next;
        ostat_reg <= ostat_next;
    end

    // An error status always carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && ostat_reg != STATUS_OK) |-> (oval_reg == 64'd0))
        else $error("error result with non-zero value");

    // A fresh result only comes out of the finishing step of a last transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg == S_FIN && last_reg))
        else $error("result raised outside the finishing step");

    // The divider keeps stepping until its bit counter runs out.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg != 6'd0) |=> (state_reg == S_DIV))
        else $error("division left early");

endmodule
